/* rtl/core/fbns_pkg.sv */
package fbns_pkg;

  // datapath micro-operations issued by the controller
  typedef logic [4:0] op_t;

  localparam op_t OP_NONE        = 5'd0;
  localparam op_t OP_LATCH       = 5'd1;
  localparam op_t OP_PAL_WR      = 5'd2;
  localparam op_t OP_PIX_STEP    = 5'd3;
  localparam op_t OP_SIZE_INIT   = 5'd4;
  localparam op_t OP_DIV_FACH    = 5'd5;
  localparam op_t OP_SAVE_FAC    = 5'd6;
  localparam op_t OP_DIV_FACW    = 5'd7;
  localparam op_t OP_MIN_FAC     = 5'd8;
  localparam op_t OP_MUL_WF      = 5'd9;
  localparam op_t OP_W_FROM_PROD = 5'd10;
  localparam op_t OP_MUL_HF      = 5'd11;
  localparam op_t OP_H_FROM_PROD = 5'd12;
  localparam op_t OP_MUL_ONE     = 5'd13;
  localparam op_t OP_DIV_ONE     = 5'd14;
  localparam op_t OP_ONE_SAVE    = 5'd15;
  localparam op_t OP_FRAME_START = 5'd16;
  localparam op_t OP_MUL_MAP     = 5'd17;
  localparam op_t OP_DIV_MAP     = 5'd18;
  localparam op_t OP_MAP_SAVE    = 5'd19;

  // request types
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_PAL_WR = 2'd1;
  localparam logic [1:0] REQ_PIXEL  = 2'd2;

  // color modes
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_INDEX   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_BOX_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_BOX_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_COLOR_MODE = 3'd4;

  // register reset values
  localparam logic [9:0] RST_BOX_WIDTH  = 10'd249;
  localparam logic [9:0] RST_BOX_HEIGHT = 10'd384;

  // shared divider geometry
  localparam int DIV_NW = 22;
  localparam int DIV_DW = 12;
  localparam int CNT_W  = $clog2(DIV_NW + 1);

  typedef struct packed {
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       active;
    logic       match;
    logic       w_over;
    logic       h_over;
    logic       div_busy;
    logic       out_free;
  } stat_t;

endpackage

/* rtl/core/fbns_div.sv */
module fbns_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [fbns_pkg::DIV_NW-1:0]     dividend,
  input  logic [fbns_pkg::DIV_DW-1:0]     divisor,
  output logic                            busy,
  output logic [fbns_pkg::DIV_NW-1:0]     quotient
);

  logic [fbns_pkg::CNT_W-1:0]  cnt;
  logic [fbns_pkg::DIV_DW-1:0] rem;
  logic [fbns_pkg::DIV_DW-1:0] dsr;
  logic [fbns_pkg::DIV_NW-1:0] quo;
  logic [fbns_pkg::DIV_DW:0]   rem_sh;
  logic [fbns_pkg::DIV_DW:0]   diff;
  logic                        take;

  // restoring division, one quotient bit a cycle, dividend shifts out of quo
  assign rem_sh = {rem, quo[fbns_pkg::DIV_NW-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign take   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= fbns_pkg::CNT_W'(fbns_pkg::DIV_NW);
    end else if (cnt != '0) begin
      cnt <= cnt - fbns_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[fbns_pkg::DIV_NW-2:0], take};
      rem <= take ? diff[fbns_pkg::DIV_DW-1:0] : rem_sh[fbns_pkg::DIV_DW-1:0];
    end
  end

  assign busy     = cnt != '0;
  assign quotient = quo;

endmodule

/* rtl/core/fbns_datapath.sv */
module fbns_datapath #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [11:0]          cfg_wr_data,
  input  logic [39:0]          s_tdata,     // pixel_value, pal_index, pal_color
  input  logic [1:0]           s_tuser,     // req_type
  input  logic                 m_tready,
  input  fbns_pkg::cmd_t       cmd,
  output fbns_pkg::stat_t      stat,
  output logic                 m_tvalid,
  output logic [39:0]          m_tdata,     // out_pixel, out_width, out_height, zero pad
  output logic                 m_tuser,     // result_kind
  output logic                 m_tlast
);

  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // configuration registers
  logic [11:0] src_width;
  logic [11:0] src_height;
  logic [9:0]  box_width;
  logic [9:0]  box_height;
  logic [1:0]  color_mode;

  // request and configuration captured at accept
  logic [1:0]  req_l;
  logic [15:0] pv_l;
  logic [7:0]  pi_l;
  logic [15:0] pc_l;
  logic [11:0] sw_l;
  logic [11:0] sh_l;
  logic [9:0]  mw_l;
  logic [9:0]  mh_l;
  logic [1:0]  mode_l;

  // palette
  logic [15:0]              pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_valid;
  logic [15:0]              pal_q;
  logic                     pal_hit_q;
  logic [PAW-1:0]           rd_addr;
  logic                     rd_in_range;
  logic                     wr_in_range;

  // frame state
  logic [9:0]  fw;
  logic [9:0]  fh;
  logic [11:0] scol;
  logic [11:0] srow;
  logic [11:0] wcol;
  logic [11:0] wrow;
  logic [9:0]  ocol;
  logic [9:0]  orow;
  logic        active;
  logic        row_wrap;

  // size computation temporaries
  logic [11:0] w_tmp;
  logic [11:0] h_tmp;
  logic [7:0]  fac;
  logic [23:0] prod;
  logic [11:0] mul_a;
  logic [11:0] mul_b;

  // staged result and output register
  logic        res_kind;
  logic [15:0] res_pixel;
  logic        res_last;
  logic        out_valid;
  logic        out_kind;
  logic [15:0] out_pixel;
  logic [9:0]  out_w;
  logic [9:0]  out_h;
  logic        out_last;

  // divider
  logic                        div_start;
  logic [fbns_pkg::DIV_NW-1:0] div_dividend;
  logic [fbns_pkg::DIV_DW-1:0] div_divisor;
  logic                        div_busy;
  logic [fbns_pkg::DIV_NW-1:0] div_quo;

  logic        w_over;
  logic        h_over;
  logic        match;
  logic [12:0] scol_inc;
  logic [12:0] srow_inc;
  logic [9:0]  ocol_inc;
  logic [9:0]  orow_inc;
  logic        last_px;
  logic [15:0] pix_color;
  logic [7:0]  q_fac;

  function automatic logic [9:0] clamp10(input logic [9:0] v);
    clamp10 = (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic [11:0] clamp12(input logic [11:0] v);
    clamp12 = (v == 12'd0) ? 12'd1 : v;
  endfunction

  assign w_over   = sw_l > {2'b00, mw_l};
  assign h_over   = sh_l > {2'b00, mh_l};
  assign match    = active && (ocol < fw) && (orow < fh) &&
                    (srow == wrow) && (scol == wcol);
  assign scol_inc = {1'b0, scol} + 13'd1;
  assign srow_inc = {1'b0, srow} + 13'd1;
  assign ocol_inc = ocol + 10'd1;
  assign orow_inc = orow + 10'd1;
  assign last_px  = (orow_inc == fh) && (ocol_inc == fw);
  assign q_fac    = div_quo[7:0];

  assign rd_addr     = s_tdata[PAW-1:0];
  assign rd_in_range = {1'b0, s_tdata[7:0]} < 9'(PALETTE_DEPTH);
  assign wr_in_range = {1'b0, pi_l} < 9'(PALETTE_DEPTH);

  always_comb begin
    case (mode_l)
      fbns_pkg::MODE_PALETTE: pix_color = pal_hit_q ? pal_q : 16'd0;
      fbns_pkg::MODE_INDEX:   pix_color = {8'h00, pv_l[7:0]};
      default:                pix_color = pv_l;
    endcase
  end

  always_comb begin
    case (cmd.op)
      fbns_pkg::OP_MUL_WF: begin
        mul_a = sw_l;
        mul_b = {4'h0, fac};
      end
      fbns_pkg::OP_MUL_HF: begin
        mul_a = sh_l;
        mul_b = {4'h0, fac};
      end
      fbns_pkg::OP_MUL_ONE: begin
        mul_a = w_over ? sh_l : sw_l;
        mul_b = w_over ? {2'b00, mw_l} : {2'b00, mh_l};
      end
      fbns_pkg::OP_MUL_MAP: begin
        mul_a = row_wrap ? {2'b00, orow} : {2'b00, ocol};
        mul_b = row_wrap ? sh_l : sw_l;
      end
      default: begin
        mul_a = 12'd0;
        mul_b = 12'd0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    case (cmd.op)
      fbns_pkg::OP_DIV_FACH: begin
        div_dividend = {4'h0, mh_l, 8'h00};
        div_divisor  = sh_l;
      end
      fbns_pkg::OP_DIV_FACW: begin
        div_dividend = {4'h0, mw_l, 8'h00};
        div_divisor  = sw_l;
      end
      fbns_pkg::OP_DIV_ONE: begin
        div_dividend = prod[21:0];
        div_divisor  = w_over ? sw_l : sh_l;
      end
      fbns_pkg::OP_DIV_MAP: begin
        div_dividend = prod[21:0];
        div_divisor  = row_wrap ? {2'b00, fh} : {2'b00, fw};
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  fbns_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 12'd1;
      src_height <= 12'd1;
      box_width  <= fbns_pkg::RST_BOX_WIDTH;
      box_height <= fbns_pkg::RST_BOX_HEIGHT;
      color_mode <= 2'd0;
      pal_valid  <= '0;
      fw         <= 10'd1;
      fh         <= 10'd1;
      scol       <= '0;
      srow       <= '0;
      wcol       <= '0;
      wrow       <= '0;
      ocol       <= '0;
      orow       <= '0;
      active     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          fbns_pkg::CFG_SRC_WIDTH:  src_width  <= cfg_wr_data;
          fbns_pkg::CFG_SRC_HEIGHT: src_height <= cfg_wr_data;
          fbns_pkg::CFG_BOX_WIDTH:  box_width  <= cfg_wr_data[9:0];
          fbns_pkg::CFG_BOX_HEIGHT: box_height <= cfg_wr_data[9:0];
          fbns_pkg::CFG_COLOR_MODE: color_mode <= cfg_wr_data[1:0];
          default: ;
        endcase
      end

      case (cmd.op)
        fbns_pkg::OP_PAL_WR: begin
          if (wr_in_range) pal_valid[pi_l[PAW-1:0]] <= 1'b1;
        end
        fbns_pkg::OP_PIX_STEP: begin
          if (scol_inc >= {1'b0, sw_l}) begin
            scol <= '0;
            if (srow_inc >= {1'b0, sh_l}) begin
              srow   <= '0;
              active <= 1'b0;
            end else begin
              srow <= srow_inc[11:0];
            end
          end else begin
            scol <= scol_inc[11:0];
          end
          if (match) begin
            if (ocol_inc >= fw) begin
              ocol <= '0;
              orow <= orow_inc;
            end else begin
              ocol <= ocol_inc;
            end
          end
        end
        fbns_pkg::OP_MAP_SAVE: begin
          if (row_wrap) begin
            wrow <= div_quo[11:0];
            wcol <= '0;
          end else begin
            wcol <= div_quo[11:0];
          end
        end
        fbns_pkg::OP_FRAME_START: begin
          fw     <= clamp10(w_tmp[9:0]);
          fh     <= clamp10(h_tmp[9:0]);
          scol   <= '0;
          srow   <= '0;
          wcol   <= '0;
          wrow   <= '0;
          ocol   <= '0;
          orow   <= '0;
          active <= 1'b1;
        end
        default: ;
      endcase

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // palette memory
  always_ff @(posedge clk) begin
    if (cmd.op == fbns_pkg::OP_PAL_WR && wr_in_range) begin
      pal_mem[pi_l[PAW-1:0]] <= pc_l;
    end
    if (cmd.op == fbns_pkg::OP_LATCH) begin
      pal_q <= pal_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      fbns_pkg::OP_LATCH: begin
        req_l     <= s_tuser;
        pv_l      <= s_tdata[15:0];
        pi_l      <= s_tdata[23:16];
        pc_l      <= s_tdata[39:24];
        sw_l      <= clamp12(src_width);
        sh_l      <= clamp12(src_height);
        mw_l      <= clamp10(box_width);
        mh_l      <= clamp10(box_height);
        mode_l    <= color_mode;
        pal_hit_q <= rd_in_range && pal_valid[rd_addr];
      end
      fbns_pkg::OP_PIX_STEP: begin
        res_kind  <= 1'b1;
        res_pixel <= pix_color;
        res_last  <= last_px;
        row_wrap  <= ocol_inc >= fw;
      end
      fbns_pkg::OP_SIZE_INIT: begin
        w_tmp <= w_over ? {2'b00, mw_l} : sw_l;
        h_tmp <= h_over ? {2'b00, mh_l} : sh_l;
      end
      fbns_pkg::OP_SAVE_FAC:    fac   <= q_fac;
      fbns_pkg::OP_MIN_FAC:     fac   <= (q_fac < fac) ? q_fac : fac;
      fbns_pkg::OP_W_FROM_PROD: w_tmp <= prod[19:8];
      fbns_pkg::OP_H_FROM_PROD: h_tmp <= prod[19:8];
      fbns_pkg::OP_ONE_SAVE: begin
        if (w_over) h_tmp <= div_quo[11:0];
        else        w_tmp <= div_quo[11:0];
      end
      fbns_pkg::OP_FRAME_START: begin
        res_kind  <= 1'b0;
        res_pixel <= 16'd0;
        res_last  <= 1'b0;
      end
      default: ;
    endcase

    if (cmd.op == fbns_pkg::OP_MUL_WF || cmd.op == fbns_pkg::OP_MUL_HF ||
        cmd.op == fbns_pkg::OP_MUL_ONE || cmd.op == fbns_pkg::OP_MUL_MAP) begin
      prod <= {12'd0, mul_a} * {12'd0, mul_b};
    end

    if (cmd.out_load) begin
      out_kind  <= res_kind;
      out_pixel <= res_pixel;
      out_w     <= fw;
      out_h     <= fh;
      out_last  <= res_last;
    end
  end

  assign stat.req      = req_l;
  assign stat.active   = active;
  assign stat.match    = match;
  assign stat.w_over   = w_over;
  assign stat.h_over   = h_over;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'h0, out_h, out_w, out_pixel};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

/* rtl/core/fbns_ctrl.sv */
module fbns_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  fbns_pkg::stat_t  stat,
  output logic             s_tready,
  output fbns_pkg::cmd_t   cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_FH_DIV  = 5'd2;
  localparam logic [4:0] S_FH_WAIT = 5'd3;
  localparam logic [4:0] S_FW_DIV  = 5'd4;
  localparam logic [4:0] S_FW_WAIT = 5'd5;
  localparam logic [4:0] S_MUL_W   = 5'd6;
  localparam logic [4:0] S_W_SAVE  = 5'd7;
  localparam logic [4:0] S_MUL_H   = 5'd8;
  localparam logic [4:0] S_H_SAVE  = 5'd9;
  localparam logic [4:0] S_ONE_MUL = 5'd10;
  localparam logic [4:0] S_ONE_DIV = 5'd11;
  localparam logic [4:0] S_ONE_WT  = 5'd12;
  localparam logic [4:0] S_FRAME   = 5'd13;
  localparam logic [4:0] S_MAP_MUL = 5'd14;
  localparam logic [4:0] S_MAP_DIV = 5'd15;
  localparam logic [4:0] S_MAP_WT  = 5'd16;
  localparam logic [4:0] S_OUT     = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = fbns_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = fbns_pkg::OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req)
          fbns_pkg::REQ_START: begin
            cmd.op = fbns_pkg::OP_SIZE_INIT;
            if (stat.w_over && stat.h_over)      state_next = S_FH_DIV;
            else if (stat.w_over || stat.h_over) state_next = S_ONE_MUL;
            else                                 state_next = S_FRAME;
          end
          fbns_pkg::REQ_PAL_WR: begin
            cmd.op     = fbns_pkg::OP_PAL_WR;
            state_next = S_IDLE;
          end
          fbns_pkg::REQ_PIXEL: begin
            if (stat.active) begin
              cmd.op     = fbns_pkg::OP_PIX_STEP;
              state_next = stat.match ? S_MAP_MUL : S_IDLE;
            end else begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      // both sides over the box: common 0.8 factor
      S_FH_DIV: begin
        cmd.op     = fbns_pkg::OP_DIV_FACH;
        state_next = S_FH_WAIT;
      end
      S_FH_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = fbns_pkg::OP_SAVE_FAC;
          state_next = S_FW_DIV;
        end
      end
      S_FW_DIV: begin
        cmd.op     = fbns_pkg::OP_DIV_FACW;
        state_next = S_FW_WAIT;
      end
      S_FW_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = fbns_pkg::OP_MIN_FAC;
          state_next = S_MUL_W;
        end
      end
      S_MUL_W: begin
        cmd.op     = fbns_pkg::OP_MUL_WF;
        state_next = S_W_SAVE;
      end
      S_W_SAVE: begin
        cmd.op     = fbns_pkg::OP_W_FROM_PROD;
        state_next = S_MUL_H;
      end
      S_MUL_H: begin
        cmd.op     = fbns_pkg::OP_MUL_HF;
        state_next = S_H_SAVE;
      end
      S_H_SAVE: begin
        cmd.op     = fbns_pkg::OP_H_FROM_PROD;
        state_next = S_FRAME;
      end
      // one side over the box: scale the other in proportion
      S_ONE_MUL: begin
        cmd.op     = fbns_pkg::OP_MUL_ONE;
        state_next = S_ONE_DIV;
      end
      S_ONE_DIV: begin
        cmd.op     = fbns_pkg::OP_DIV_ONE;
        state_next = S_ONE_WT;
      end
      S_ONE_WT: begin
        if (!stat.div_busy) begin
          cmd.op     = fbns_pkg::OP_ONE_SAVE;
          state_next = S_FRAME;
        end
      end
      S_FRAME: begin
        cmd.op     = fbns_pkg::OP_FRAME_START;
        state_next = S_OUT;
      end
      // next wanted source coordinate after an emitted pixel
      S_MAP_MUL: begin
        cmd.op     = fbns_pkg::OP_MUL_MAP;
        state_next = S_MAP_DIV;
      end
      S_MAP_DIV: begin
        cmd.op     = fbns_pkg::OP_DIV_MAP;
        state_next = S_MAP_WT;
      end
      S_MAP_WT: begin
        if (!stat.div_busy) begin
          cmd.op     = fbns_pkg::OP_MAP_SAVE;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = state == S_IDLE;

endmodule

/* rtl/core/fit_box_nearest_scaler_core.sv */
// nearest-neighbor downscaler that fits a source image into a maximum box
//
// requests arrive on the s_ group, req_type in s_tuser: a start request computes
// the output size from the source size and box size registers and returns
// a size report (m_tuser 0); a palette write stores pal_color; source pixels in
// raster order return the pixels that nearest selection keeps (m_tuser 1), with
// m_tlast on the final pixel of the frame. registers are written on the cfg_ port;
// the user writes them while no request is in flight, which the block does not enforce.
// requests are taken one at a time and use the shared divider. a pixel not kept, a palette
// write and an unused code return nothing; a kept pixel adds a multiply and a division
// for the next wanted coordinate; a start adds no arithmetic inside the box, a multiply
// and a division with one side over, and two of each with both sides over.
// the result sits in an output register, so the next request is taken while it
// waits; if m_tready stays low the block stalls only once a second result is due.
// reset clears the registers to their defaults, marks the palette empty so its entries
// read as zero, and leaves no frame active; source pixels outside a frame are dropped.
module fit_box_nearest_scaler_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pixel_value[15:0], pal_index[23:16], pal_color[39:24]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_pixel[15:0], out_width[25:16], out_height[35:26]
  output logic        m_tuser,   // result_kind
  output logic        m_tlast    // frame_last
);

  fbns_pkg::cmd_t  cmd;
  fbns_pkg::stat_t stat;

  fbns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  fbns_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tready    (m_tready),
    .cmd         (cmd),
    .stat        (stat),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten while holding a result");

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !s_tready)
    else $error("request taken while the divider is running");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == 1'b0)) |-> ((m_tdata[15:0] == 16'd0) && !m_tlast))
    else $error("size report carries pixel data or last flag");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[25:16] != 10'd0) && (m_tdata[35:26] != 10'd0)))
    else $error("zero output size on the result channel");

endmodule
